// ===== rtl/qfts_pkg.sv =====
// ----------------------------------------------------------------------------
// qfts_pkg
// Shared types and constants of the two-stack queue.
// ----------------------------------------------------------------------------
package qfts_pkg;

    localparam int CAP_W     = 5;
    localparam int CFG_IDX_W = 1;
    localparam int STATUS_W  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_CAP_FIRST  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAP_SECOND = 1'd1;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic KIND_ENQ = 1'b0;
    localparam logic KIND_DEQ = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOVE,
        S_DRAIN,
        S_PUSH,
        S_POP,
        S_REPLY
    } seq_state_t;

    // Result offered by the sequencer to the output register
    typedef struct packed {
        logic    valid;
        status_t status;
    } reply_t;

endpackage

// ===== rtl/qfts_if.sv =====
// ----------------------------------------------------------------------------
// qfts_if
// Request and response channels of the two-stack queue.
// ----------------------------------------------------------------------------
interface qfts_req_if #(
    parameter int ITEM_WIDTH = 32
);
    logic                         valid;
    logic                         ready;
    logic                         kind;
    logic signed [ITEM_WIDTH-1:0] item_value;

    modport source (output valid, kind, item_value, input ready);
    modport sink   (input valid, kind, item_value, output ready);
endinterface

interface qfts_rsp_if #(
    parameter int ITEM_WIDTH = 32
);
    logic                           valid;
    logic                           ready;
    logic [qfts_pkg::STATUS_W-1:0]  status;
    logic signed [ITEM_WIDTH-1:0]   value_out;

    modport source (output valid, status, value_out, input ready);
    modport sink   (input valid, status, value_out, output ready);
endinterface

// ===== rtl/queue_from_two_stacks.sv =====
// A refill of the output stack moves one entry per cycle through the RAM read port.
// One item is in work at a time; the next request is taken once the current one is
// done: a successful enqueue ends with no result, any other once its result is held.
// Reset clears both counts and the output valid flag and sets both capacities to 16;
// stack contents are not cleared.
// ----------------------------------------------------------------------------
// queue_from_two_stacks
// FIFO built from two bounded stacks; the input stack is limited to the smaller capacity.
// ----------------------------------------------------------------------------
module queue_from_two_stacks #(
    parameter int STACK_DEPTH = 16,
    parameter int ITEM_WIDTH  = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    qfts_req_if.sink                       req,
    qfts_rsp_if.source                     rsp,
    input  logic                           cfg_we,
    input  logic [qfts_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [qfts_pkg::CAP_W-1:0]     cfg_wdata
);

    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam int LIM_W = (CNT_W > qfts_pkg::CAP_W) ? CNT_W : qfts_pkg::CAP_W;
    localparam logic [LIM_W-1:0] DEPTH_L = LIM_W'(STACK_DEPTH);

    logic [qfts_pkg::CAP_W-1:0] cap_first_reg;
    logic [qfts_pkg::CAP_W-1:0] cap_second_reg;

    logic [LIM_W-1:0] cap_a;
    logic [LIM_W-1:0] cap_b;
    logic [LIM_W-1:0] lim_w;

    qfts_pkg::reply_t      reply;
    logic                  reply_take;
    logic [ITEM_WIDTH-1:0] reply_value;

    logic                          out_valid_reg;
    logic [qfts_pkg::STATUS_W-1:0] out_status_reg;
    logic [ITEM_WIDTH-1:0]         out_value_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_first_reg  <= qfts_pkg::CAP_RESET;
            cap_second_reg <= qfts_pkg::CAP_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                qfts_pkg::CFG_CAP_FIRST:  cap_first_reg  <= cfg_wdata;
                qfts_pkg::CFG_CAP_SECOND: cap_second_reg <= cfg_wdata;
                default:
                begin
                end
            endcase
        end
    end

    // Saturate each capacity into 1..STACK_DEPTH, then take the smaller
    always_comb
    begin
        cap_a = LIM_W'(cap_first_reg);
        cap_b = LIM_W'(cap_second_reg);
        if (cap_a == '0)
        begin
            cap_a = LIM_W'(1);
        end
        else if (cap_a > DEPTH_L)
        begin
            cap_a = DEPTH_L;
        end
        if (cap_b == '0)
        begin
            cap_b = LIM_W'(1);
        end
        else if (cap_b > DEPTH_L)
        begin
            cap_b = DEPTH_L;
        end
        lim_w = (cap_a < cap_b) ? cap_a : cap_b;
    end

    qfts_seq #(
        .STACK_DEPTH (STACK_DEPTH),
        .ITEM_WIDTH  (ITEM_WIDTH)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req.valid),
        .req_ready   (req.ready),
        .req_kind    (req.kind),
        .req_item    (req.item_value),
        .lim         (lim_w[CNT_W-1:0]),
        .reply       (reply),
        .reply_take  (reply_take),
        .reply_value (reply_value)
    );

    // Take the result once the output register is free or being drained
    assign reply_take = reply.valid && (!out_valid_reg || rsp.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (reply_take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (reply_take)
        begin
            out_status_reg <= reply.status;
            out_value_reg  <= reply_value;
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.status    = out_status_reg;
    assign rsp.value_out = out_value_reg;

    // A pending result keeps the request side closed
    a_reply_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        reply.valid |-> !req.ready)
        else $error("request accepted while a result is pending");

    // An accepted request drops ready in the cycle after the transfer
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("ready held high after a transfer");

    // Error results carry a zero value
    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.status != qfts_pkg::ST_OK)) |-> (rsp.value_out == '0))
        else $error("non-zero value on an error result");

endmodule

// ===== rtl/qfts_ram.sv =====
// ----------------------------------------------------------------------------
// qfts_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module qfts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/qfts_seq.sv =====
// ----------------------------------------------------------------------------
// qfts_seq
// Sequencer of the two-stack queue: both stacks, their counts, and the
// one-entry-per-cycle move of the input stack into the output stack.
// ----------------------------------------------------------------------------
module qfts_seq #(
    parameter int STACK_DEPTH = 16,
    parameter int ITEM_WIDTH  = 32,
    localparam int CNT_W = $clog2(STACK_DEPTH + 1),
    localparam int IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  logic                  req_kind,
    input  logic [ITEM_WIDTH-1:0] req_item,
    input  logic [CNT_W-1:0]      lim,
    output qfts_pkg::reply_t      reply,
    input  logic                  reply_take,
    output logic [ITEM_WIDTH-1:0] reply_value
);

    qfts_pkg::seq_state_t state_reg, state_next;
    qfts_pkg::status_t    status_reg, status_next;

    logic                  kind_reg, kind_next;
    logic [ITEM_WIDTH-1:0] item_reg, item_next;
    logic [CNT_W-1:0]      in_count_reg, in_count_next;
    logic [CNT_W-1:0]      out_count_reg, out_count_next;
    logic [IDX_W-1:0]      j_reg, j_next;
    logic                  mv_we_reg, mv_we_next;
    logic [IDX_W-1:0]      mv_addr_reg, mv_addr_next;

    logic                  accept;
    logic                  move_last;
    logic [CNT_W-1:0]      in_rd_pos;
    logic [CNT_W-1:0]      out_top_pos;
    logic [ITEM_WIDTH-1:0] in_rdata;
    logic [ITEM_WIDTH-1:0] out_rdata;

    assign req_ready = (state_reg == qfts_pkg::S_IDLE);
    assign accept    = req_valid && req_ready;

    // Read the input stack from its top down while the output stack fills up
    assign in_rd_pos   = in_count_reg - CNT_W'(1) - CNT_W'(j_reg);
    assign out_top_pos = out_count_reg - CNT_W'(1);
    assign move_last   = (CNT_W'(j_reg) == (in_count_reg - CNT_W'(1)));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            qfts_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    if (req_kind == qfts_pkg::KIND_ENQ)
                    begin
                        if (in_count_reg < lim)
                        begin
                            state_next = qfts_pkg::S_PUSH;
                        end
                        else if (out_count_reg == '0)
                        begin
                            state_next = qfts_pkg::S_MOVE;
                        end
                        else
                        begin
                            state_next = qfts_pkg::S_REPLY;
                        end
                    end
                    else
                    begin
                        if (out_count_reg != '0)
                        begin
                            state_next = qfts_pkg::S_POP;
                        end
                        else if (in_count_reg != '0)
                        begin
                            state_next = qfts_pkg::S_MOVE;
                        end
                        else
                        begin
                            state_next = qfts_pkg::S_REPLY;
                        end
                    end
                end
            end
            qfts_pkg::S_MOVE:
            begin
                if (move_last)
                begin
                    state_next = qfts_pkg::S_DRAIN;
                end
            end
            qfts_pkg::S_DRAIN:
            begin
                state_next = (kind_reg == qfts_pkg::KIND_ENQ) ? qfts_pkg::S_PUSH
                                                               : qfts_pkg::S_POP;
            end
            qfts_pkg::S_PUSH:  state_next = qfts_pkg::S_IDLE;
            qfts_pkg::S_POP:   state_next = qfts_pkg::S_REPLY;
            qfts_pkg::S_REPLY:
            begin
                if (reply_take)
                begin
                    state_next = qfts_pkg::S_IDLE;
                end
            end
            default: state_next = qfts_pkg::S_IDLE;
        endcase
    end

    // Datapath updates
    always_comb
    begin
        kind_next      = kind_reg;
        item_next      = item_reg;
        status_next    = status_reg;
        in_count_next  = in_count_reg;
        out_count_next = out_count_reg;
        j_next         = j_reg;
        mv_we_next     = 1'b0;
        mv_addr_next   = j_reg;
        case (state_reg)
            qfts_pkg::S_IDLE:
            begin
                j_next = '0;
                if (accept)
                begin
                    kind_next = req_kind;
                    item_next = req_item;
                    status_next = (req_kind == qfts_pkg::KIND_ENQ) ? qfts_pkg::ST_FULL
                                                                    : qfts_pkg::ST_EMPTY;
                end
            end
            qfts_pkg::S_MOVE:
            begin
                mv_we_next = 1'b1;
                j_next     = j_reg + IDX_W'(1);
            end
            qfts_pkg::S_DRAIN:
            begin
                out_count_next = in_count_reg;
                in_count_next  = '0;
            end
            qfts_pkg::S_PUSH:
            begin
                in_count_next = in_count_reg + CNT_W'(1);
            end
            qfts_pkg::S_POP:
            begin
                out_count_next = out_top_pos;
                status_next    = qfts_pkg::ST_OK;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= qfts_pkg::S_IDLE;
            in_count_reg  <= '0;
            out_count_reg <= '0;
            mv_we_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            in_count_reg  <= in_count_next;
            out_count_reg <= out_count_next;
            mv_we_reg     <= mv_we_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg    <= kind_next;
        item_reg    <= item_next;
        status_reg  <= status_next;
        j_reg       <= j_next;
        mv_addr_reg <= mv_addr_next;
    end

    qfts_ram #(
        .WIDTH (ITEM_WIDTH),
        .DEPTH (STACK_DEPTH)
    ) u_in_stack (
        .clk   (clk),
        .we    (state_reg == qfts_pkg::S_PUSH),
        .waddr (in_count_reg[IDX_W-1:0]),
        .wdata (item_reg),
        .re    (state_reg == qfts_pkg::S_MOVE),
        .raddr (in_rd_pos[IDX_W-1:0]),
        .rdata (in_rdata)
    );

    // Each write lands in the cycle after its input-stack read
    qfts_ram #(
        .WIDTH (ITEM_WIDTH),
        .DEPTH (STACK_DEPTH)
    ) u_out_stack (
        .clk   (clk),
        .we    (mv_we_reg),
        .waddr (mv_addr_reg),
        .wdata (in_rdata),
        .re    (state_reg == qfts_pkg::S_POP),
        .raddr (out_top_pos[IDX_W-1:0]),
        .rdata (out_rdata)
    );

    assign reply.valid  = (state_reg == qfts_pkg::S_REPLY);
    assign reply.status = status_reg;
    assign reply_value  = (status_reg == qfts_pkg::ST_OK) ? out_rdata : '0;

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the two-stack queue. Enqueues and dequeues go in
// over the request channel and are mirrored in a local queue predictor.
// Every response transfer is checked field by field against the oldest
// predicted reply. Capacities are changed only while the block is idle.
// ----------------------------------------------------------------------------
module tb;

    localparam int DEPTH         = 16;
    localparam int VAL_W         = 32;
    localparam int SETTLE_CYCLES = 40;
    localparam int STALL_LIMIT   = 2000;
    localparam int HOLD_STRETCH  = 300;

    typedef logic [qfts_pkg::CAP_W-1:0] cap_t;

    typedef struct {
        qfts_pkg::status_t       status;
        logic signed [VAL_W-1:0] value;
    } queue_reply_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [qfts_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [qfts_pkg::CAP_W-1:0]     cfg_wdata;

    qfts_req_if #(.ITEM_WIDTH(VAL_W)) req_ch ();
    qfts_rsp_if #(.ITEM_WIDTH(VAL_W)) rsp_ch ();

    queue_from_two_stacks #(
        .STACK_DEPTH (DEPTH),
        .ITEM_WIDTH  (VAL_W)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // Predictor state
    logic signed [VAL_W-1:0]    in_stack  [DEPTH];
    logic signed [VAL_W-1:0]    out_stack [DEPTH];
    int unsigned                in_count;
    int unsigned                out_count;
    logic [qfts_pkg::CAP_W-1:0] cap_first;
    logic [qfts_pkg::CAP_W-1:0] cap_second;

    queue_reply_t pending_replies [$];
    int           errors;
    bit           tx_idle_on;
    bit           rx_idle_on;
    int           hold_cycles;
    int           stall_count;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic int unsigned clamp_capacity(input logic [qfts_pkg::CAP_W-1:0] c);
        if (c == 0)
            return 1;
        if (c > DEPTH)
            return DEPTH;
        return c;
    endfunction

    // Move the whole input stack over, oldest item ending on top
    function automatic void refill_output();
        for (int j = 0; j < in_count; j++)
            out_stack[j] = in_stack[in_count - 1 - j];
        out_count = in_count;
        in_count  = 0;
    endfunction

    function automatic void predict_queue_op(input logic kind,
                                             input logic signed [VAL_W-1:0] value);
        int unsigned limit_now;
        int unsigned a;
        int unsigned b;
        a = clamp_capacity(cap_first);
        b = clamp_capacity(cap_second);
        limit_now = (a < b) ? a : b;
        if (kind == qfts_pkg::KIND_ENQ)
        begin
            if (in_count < limit_now)
            begin
                in_stack[in_count] = value;
                in_count++;
            end
            else if (out_count == 0)
            begin
                refill_output();
                in_stack[0] = value;
                in_count    = 1;
            end
            else
                pending_replies.push_back('{qfts_pkg::ST_FULL, '0});
        end
        else
        begin
            if (out_count == 0 && in_count == 0)
                pending_replies.push_back('{qfts_pkg::ST_EMPTY, '0});
            else
            begin
                if (out_count == 0)
                    refill_output();
                out_count--;
                pending_replies.push_back('{qfts_pkg::ST_OK, out_stack[out_count]});
            end
        end
    endfunction

    function automatic logic signed [VAL_W-1:0] random_value();
        case ($urandom_range(15))
            0:       return {1'b1, {(VAL_W-1){1'b0}}};
            1:       return {1'b0, {(VAL_W-1){1'b1}}};
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // Call at a rising edge; returns at the edge of the transfer
    task automatic send_op(input logic kind, input logic signed [VAL_W-1:0] value);
        if (tx_idle_on && $urandom_range(99) < 36)
        begin
            req_ch.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < 36);
        end
        req_ch.valid      <= 1'b1;
        req_ch.kind       <= kind;
        req_ch.item_value <= value;
        do
            @(posedge clk);
        while (!req_ch.ready);
        predict_queue_op(kind, value);
    endtask

    // Drop valid, drain every reply, then let any silent enqueue finish
    task automatic wait_quiescent();
        req_ch.valid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_capacities(input logic [qfts_pkg::CAP_W-1:0] first,
                                  input logic [qfts_pkg::CAP_W-1:0] second);
        cfg_we    <= 1'b1;
        cfg_index <= qfts_pkg::CFG_CAP_FIRST;
        cfg_wdata <= first;
        @(posedge clk);
        cfg_index <= qfts_pkg::CFG_CAP_SECOND;
        cfg_wdata <= second;
        @(posedge clk);
        cfg_we     <= 1'b0;
        cap_first  = first;
        cap_second = second;
    endtask

    task automatic run_random_phase(input int n_items, input int enq_pct);
        for (int i = 0; i < n_items; i++)
            send_op(($urandom_range(99) < enq_pct) ? qfts_pkg::KIND_ENQ
                                                   : qfts_pkg::KIND_DEQ,
                    random_value());
        wait_quiescent();
    endtask

    // Empty error at reset, extremes of the value field, FIFO order
    task automatic test_reset_defaults();
        send_op(qfts_pkg::KIND_DEQ, '1);
        send_op(qfts_pkg::KIND_ENQ, {1'b1, {(VAL_W-1){1'b0}}});
        send_op(qfts_pkg::KIND_ENQ, {1'b0, {(VAL_W-1){1'b1}}});
        send_op(qfts_pkg::KIND_ENQ, '0);
        send_op(qfts_pkg::KIND_ENQ, '1);
        repeat (4) send_op(qfts_pkg::KIND_DEQ, $urandom);
        wait_quiescent();
    endtask

    // Limit lowered under the input count, full error, tall output stack
    task automatic test_lowered_limit();
        for (int i = 1; i <= 3; i++)
            send_op(qfts_pkg::KIND_ENQ, i);
        wait_quiescent();
        set_capacities(5'd2, 5'd3);
        send_op(qfts_pkg::KIND_ENQ, 4);
        send_op(qfts_pkg::KIND_ENQ, 5);
        send_op(qfts_pkg::KIND_ENQ, 6);
        repeat (6) send_op(qfts_pkg::KIND_DEQ, '0);
        wait_quiescent();
    endtask

    // Capacities outside 1..16 saturate
    task automatic test_saturation();
        set_capacities(5'd0, 5'd31);
        send_op(qfts_pkg::KIND_ENQ, 32'h1234_5678);
        send_op(qfts_pkg::KIND_ENQ, 32'h8765_4321);
        send_op(qfts_pkg::KIND_ENQ, 32'h0bad_cafe);
        repeat (3) send_op(qfts_pkg::KIND_DEQ, '0);
        wait_quiescent();
    endtask

    task automatic test_random_mix();
        logic [qfts_pkg::CAP_W-1:0] firsts  [7] = '{5'd31, 5'd1, 5'd0, 5'd16, 5'd3, 5'd20, 5'd8};
        logic [qfts_pkg::CAP_W-1:0] seconds [7] = '{5'd17, 5'd1, 5'd5, 5'd16, 5'd31, 5'd0, 5'd12};
        int                         pcts    [3] = '{70, 35, 55};
        for (int p = 0; p < 7; p++)
        begin
            set_capacities(firsts[p], seconds[p]);
            run_random_phase(50, pcts[p % 3]);
        end
        set_capacities(cap_t'($urandom_range(31)), cap_t'($urandom_range(31)));
        run_random_phase(30, 60);
    endtask

    // Receiver holds off while items keep coming, so the input stalls
    task automatic test_backpressure();
        set_capacities(5'd6, 5'd16);
        hold_cycles = HOLD_STRETCH;
        run_random_phase(40, 50);
    endtask

    task automatic test_no_idle();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        set_capacities(5'd16, 5'd16);
        run_random_phase(40, 55);
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    initial
    begin
        errors     = 0;
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        in_count   = 0;
        out_count  = 0;
        cap_first  = qfts_pkg::CAP_RESET;
        cap_second = qfts_pkg::CAP_RESET;
        rst_n             <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_index         <= qfts_pkg::CFG_CAP_FIRST;
        cfg_wdata         <= '0;
        req_ch.valid      <= 1'b0;
        req_ch.kind       <= qfts_pkg::KIND_ENQ;
        req_ch.item_value <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_lowered_limit();
        test_saturation();
        test_random_mix();
        test_backpressure();
        test_no_idle();

        wait_quiescent();
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        hold_cycles = 0;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                rsp_ch.ready <= 1'b0;
                hold_cycles--;
            end
            else if (rx_idle_on && $urandom_range(99) < 36)
                rsp_ch.ready <= 1'b0;
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        queue_reply_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_replies.size() == 0)
            begin
                $error("reply with nothing predicted: status %0d value_out %0d",
                       rsp_ch.status, rsp_ch.value_out);
                errors++;
            end
            else
            begin
                want = pending_replies.pop_front();
                if (rsp_ch.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
                    errors++;
                end
                if (rsp_ch.value_out !== want.value)
                begin
                    $error("value_out: expected %0d, got %0d", want.value, rsp_ch.value_out);
                    errors++;
                end
            end
        end
    end

    // Abort when no transfer happens on either channel for too long
    initial
    begin
        stall_count = 0;
        forever
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                stall_count = 0;
            else
                stall_count++;
            if (stall_count >= STALL_LIMIT)
            begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

endmodule

// ===== files.f =====
rtl/qfts_pkg.sv
rtl/qfts_if.sv
rtl/qfts_ram.sv
rtl/qfts_seq.sv
rtl/queue_from_two_stacks.sv
bench/tb.sv
